/* rtl/core/mnar_pkg.sv */
// Shared types and constants for the mixed number add and reduce block.
package mnar_pkg;

    localparam int SUM_WHOLE_W = 17;
    localparam int SUM_NUM_W   = 33;
    localparam int SUM_DEN_W   = 32;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL1  = 10'b00_0000_0010,
        S_MUL2  = 10'b00_0000_0100,
        S_MUL3  = 10'b00_0000_1000,
        S_ABS   = 10'b00_0001_0000,
        S_GCD   = 10'b00_0010_0000,
        S_SHIFT = 10'b00_0100_0000,
        S_DIVN  = 10'b00_1000_0000,
        S_DIVD  = 10'b01_0000_0000,
        S_WRITE = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/mnar_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module mnar_div
    import mnar_pkg::*;
#(
    parameter int SW = 34
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [SW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output div_stat_t     stat,
    output logic [SW-1:0] quotient
);

    localparam int CW = $clog2(SW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] quo_reg, quo_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic [SW:0]   shifted;
    logic [SW+1:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[SW-1]};
        diff      = (SW+2)'(shifted) - (SW+2)'(dvs_reg);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[SW+1])
            begin
                rem_next = diff[SW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* rtl/core/mixed_number_add_reduce.sv */
// Adds two mixed numbers and reduces the fraction sum by its gcd.
// The fraction sum is formed at width SW = 2*OPERAND_WIDTH+2, capped at 64, and its gcd
// is found by binary gcd steps, with K the common power of two restored by left shifts.
// One transaction at a time; the shared multiplier, the gcd subtractor and the
// divider are reused step by step.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
module mixed_number_add_reduce
    import mnar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [OPERAND_WIDTH-1:0] first_whole,
    input  logic signed [OPERAND_WIDTH-1:0] first_numerator,
    input  logic signed [OPERAND_WIDTH-1:0] first_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] second_whole,
    input  logic signed [OPERAND_WIDTH-1:0] second_numerator,
    input  logic signed [OPERAND_WIDTH-1:0] second_denominator,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SUM_WHOLE_W-1:0]   sum_whole,
    output logic signed [SUM_NUM_W-1:0]     sum_numerator,
    output logic signed [SUM_DEN_W-1:0]     sum_denominator,
    output logic                            undefined_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int SW = (2*W + 2 > 64) ? 64 : 2*W + 2;
    localparam int KW = $clog2(SW);

    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   div_start_reg, div_start_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [SW-1:0]          a_reg, a_next;
    logic [SW-1:0]          b_reg, b_next;
    logic [SW-1:0]          mag_n_reg, mag_n_next;
    logic [SW-1:0]          mag_d_reg, mag_d_next;
    logic                   num_neg_reg, num_neg_next;
    logic                   den_neg_reg, den_neg_next;
    logic                   undef_reg, undef_next;
    logic signed [W:0]      n1_reg, n1_next;
    logic signed [W:0]      d1_reg, d1_next;
    logic signed [W:0]      n2_reg, n2_next;
    logic signed [W:0]      d2_reg, d2_next;
    logic [SUM_WHOLE_W-1:0] whole_reg, whole_next;
    logic [SW-1:0]          prod_reg, prod_next;
    logic [SW-1:0]          num_reg, num_next;
    logic [SW-1:0]          rn_reg, rn_next;
    logic [SUM_WHOLE_W-1:0] sum_whole_reg, sum_whole_next;
    logic [SUM_NUM_W-1:0]   sum_num_reg, sum_num_next;
    logic [SUM_DEN_W-1:0]   sum_den_reg, sum_den_next;
    logic                   undef_out_reg, undef_out_next;

    logic signed [W:0]      mul_a, mul_b;
    logic signed [2*W+1:0]  mul_p;
    logic signed [W:0]      n1_sx, n2_sx;
    logic signed [W:0]      w1_sx, w2_sx;
    logic signed [W:0]      whole_sum;
    logic signed [63:0]     whole_ext;
    logic [SW-1:0]          gcd_or;
    logic [SW-1:0]          rn_s, rd_s;
    logic signed [63:0]     rn_ext, rd_ext;
    logic [SW-1:0]          div_dividend;
    logic [SW-1:0]          div_quotient;
    div_stat_t              div_stat;

    mnar_div #(
        .SW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (a_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign div_dividend = (state_reg == S_DIVD) ? mag_d_reg : mag_n_reg;

    always_comb
    begin
        unique case (state_reg)
            S_MUL1:
            begin
                mul_a = n1_reg;
                mul_b = d2_reg;
            end
            S_MUL2:
            begin
                mul_a = n2_reg;
                mul_b = d1_reg;
            end
            default:
            begin
                mul_a = d1_reg;
                mul_b = d2_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        n1_sx     = (W+1)'(first_numerator);
        n2_sx     = (W+1)'(second_numerator);
        w1_sx     = (W+1)'(first_whole);
        w2_sx     = (W+1)'(second_whole);
        whole_sum = w1_sx + w2_sx;
        whole_ext = 64'(whole_sum);
        gcd_or    = a_reg | b_reg;
        rn_s      = num_neg_reg ? (SW'(0) - rn_reg) : rn_reg;
        rd_s      = den_neg_reg ? (SW'(0) - b_reg) : b_reg;
        rn_ext    = 64'(signed'(rn_s));
        rd_ext    = 64'(signed'(rd_s));
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        div_start_next = 1'b0;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mag_n_next     = mag_n_reg;
        mag_d_next     = mag_d_reg;
        num_neg_next   = num_neg_reg;
        den_neg_next   = den_neg_reg;
        undef_next     = undef_reg;
        n1_next        = n1_reg;
        d1_next        = d1_reg;
        n2_next        = n2_reg;
        d2_next        = d2_reg;
        whole_next     = whole_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rn_next        = rn_reg;
        sum_whole_next = sum_whole_reg;
        sum_num_next   = sum_num_reg;
        sum_den_next   = sum_den_reg;
        undef_out_next = undef_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (first_whole[W-1] || (first_whole == '0))
                    begin
                        n1_next = (W+1)'(0) - n1_sx;
                    end
                    else
                    begin
                        n1_next = n1_sx;
                    end
                    if (second_whole[W-1] || (second_whole == '0))
                    begin
                        n2_next = (W+1)'(0) - n2_sx;
                    end
                    else
                    begin
                        n2_next = n2_sx;
                    end
                    d1_next    = (W+1)'(first_denominator);
                    d2_next    = (W+1)'(second_denominator);
                    whole_next = whole_ext[SUM_WHOLE_W-1:0];
                    undef_next = 1'b0;
                    k_next     = '0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                prod_next  = mul_p[SW-1:0];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                num_next   = prod_reg;
                prod_next  = mul_p[SW-1:0];
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                num_next   = num_reg + prod_reg;
                prod_next  = mul_p[SW-1:0];
                state_next = S_ABS;
            end
            S_ABS:
            begin
                num_neg_next = num_reg[SW-1];
                den_neg_next = prod_reg[SW-1];
                mag_n_next   = num_reg[SW-1] ? (SW'(0) - num_reg) : num_reg;
                mag_d_next   = prod_reg[SW-1] ? (SW'(0) - prod_reg) : prod_reg;
                a_next       = mag_n_next;
                b_next       = mag_d_next;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                priority if ((a_reg == '0) || (b_reg == '0))
                begin
                    a_next = gcd_or;
                    if (gcd_or == '0)
                    begin
                        undef_next = 1'b1;
                        state_next = S_WRITE;
                    end
                    else if (k_reg == '0)
                    begin
                        div_start_next = 1'b1;
                        state_next     = S_DIVN;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg >= b_reg)
                begin
                    a_next = a_reg - b_reg;
                end
                else
                begin
                    b_next = b_reg - a_reg;
                end
            end
            S_SHIFT:
            begin
                a_next = a_reg << 1;
                k_next = k_reg - KW'(1);
                if (k_reg == KW'(1))
                begin
                    div_start_next = 1'b1;
                    state_next     = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_stat.done)
                begin
                    rn_next        = div_quotient;
                    div_start_next = 1'b1;
                    state_next     = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_stat.done)
                begin
                    b_next     = div_quotient;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (undef_reg)
                    begin
                        sum_whole_next = '0;
                        sum_num_next   = '0;
                        sum_den_next   = '0;
                        undef_out_next = 1'b1;
                    end
                    else
                    begin
                        sum_whole_next = whole_reg;
                        sum_num_next   = rn_ext[SUM_NUM_W-1:0];
                        sum_den_next   = rd_ext[SUM_DEN_W-1:0];
                        undef_out_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            k_reg         <= '0;
            undef_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_start_reg <= div_start_next;
            k_reg         <= k_next;
            undef_reg     <= undef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        mag_n_reg     <= mag_n_next;
        mag_d_reg     <= mag_d_next;
        num_neg_reg   <= num_neg_next;
        den_neg_reg   <= den_neg_next;
        n1_reg        <= n1_next;
        d1_reg        <= d1_next;
        n2_reg        <= n2_next;
        d2_reg        <= d2_next;
        whole_reg     <= whole_next;
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        rn_reg        <= rn_next;
        sum_whole_reg <= sum_whole_next;
        sum_num_reg   <= sum_num_next;
        sum_den_reg   <= sum_den_next;
        undef_out_reg <= undef_out_next;
    end

    assign in_ready         = (state_reg == S_IDLE) && !div_stat.busy;
    assign out_valid        = out_valid_reg;
    assign sum_whole        = sum_whole_reg;
    assign sum_numerator    = sum_num_reg;
    assign sum_denominator  = sum_den_reg;
    assign undefined_result = undef_out_reg;

endmodule
